// ----- rtl/owner_tagged_channel_allocator_macros.svh -----
// Assertion macros shared by the checker of the owner-tagged channel allocator.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef OWNER_TAGGED_CHANNEL_ALLOCATOR_MACROS_SVH
`define OWNER_TAGGED_CHANNEL_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTCA_CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OTCA_CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/otca_pkg.sv -----
// Shared types and codes of the owner-tagged channel allocator.
// Used by the controller, the datapath, the top level and the checker.
package otca_pkg;

	// Width of the scan index and of the active channel count.
	localparam int SCAN_W = 6;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_RELEASED  = 3'd1,
		ST_OWNER     = 3'd2,
		ST_REFUSED   = 3'd3,
		ST_NONE_REL  = 3'd4,
		ST_BAD_COUNT = 3'd5,
		ST_BAD_CHAN  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CFG,
		OP_LOAD,
		OP_RECOUNT,
		OP_ALLOC,
		OP_REL,
		OP_REL_END,
		OP_SINGLE,
		OP_QRD,
		OP_QOUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    zero_cnt;
		logic    short_cnt;
		logic    bad_ch;
		logic    out_free;
		logic    alloc_done;
		logic    scan_end;
		logic    rel_done;
	} dp_stat_t;

endpackage

// ----- rtl/otca_ctrl.sv -----
// Sequencing state machine of the owner-tagged channel allocator.
// Depends on otca_pkg; drives the datapath through cmd_t and reads dp_stat_t.
module otca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cfg_valid,
	input  otca_pkg::dp_stat_t stat,
	output logic               in_ready,
	output logic               cfg_ready,
	output otca_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RECOUNT,
		S_ALLOC,
		S_REL,
		S_REL_END,
		S_SINGLE,
		S_QRD,
		S_QOUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	always_comb begin
		state_d = state_q;
		cmd.op  = otca_pkg::OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.op  = otca_pkg::OP_CFG;
					state_d = S_RECOUNT;
				end else if (in_valid) begin
					cmd.op = otca_pkg::OP_LOAD;
					case (stat.act)
						otca_pkg::ACT_ALLOC: begin
							state_d = (stat.zero_cnt || stat.short_cnt) ? S_SINGLE : S_ALLOC;
						end
						otca_pkg::ACT_RELEASE: begin
							state_d = S_REL;
						end
						otca_pkg::ACT_QUERY: begin
							state_d = stat.bad_ch ? S_SINGLE : S_QRD;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RECOUNT: begin
				cmd.op = otca_pkg::OP_RECOUNT;
				if (stat.scan_end) begin
					state_d = S_IDLE;
				end
			end
			S_ALLOC: begin
				cmd.op = otca_pkg::OP_ALLOC;
				if (stat.alloc_done) begin
					state_d = S_IDLE;
				end
			end
			S_REL: begin
				cmd.op = otca_pkg::OP_REL;
				if (stat.rel_done) begin
					state_d = S_REL_END;
				end
			end
			S_REL_END: begin
				cmd.op = otca_pkg::OP_REL_END;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SINGLE: begin
				cmd.op = otca_pkg::OP_SINGLE;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_QRD: begin
				cmd.op  = otca_pkg::OP_QRD;
				state_d = S_QOUT;
			end
			S_QOUT: begin
				cmd.op = otca_pkg::OP_QOUT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/otca_dpath.sv -----
// Datapath of the owner-tagged channel allocator: free marks, owner tag memory,
// free counter, channel scan with one read stage, release hold stage and result register.
// Depends on otca_pkg; commanded by otca_ctrl.
module otca_dpath #(
	parameter int MAX_CHANNELS = 32,
	parameter int OWNER_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  otca_pkg::cmd_t     cmd,
	output otca_pkg::dp_stat_t stat,
	input  logic [1:0]         action,
	input  logic [15:0]        owner_id,
	input  logic [5:0]         count,
	input  logic [5:0]         channel,
	input  logic [5:0]         channels_in_use,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic [4:0]         channel_out,
	output logic [15:0]        owner_out,
	output logic               channel_free,
	output logic [5:0]         free_total,
	output logic               last
);

	localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int TW   = (OWNER_BITS < 16) ? OWNER_BITS : 16;
	localparam int NRST = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
	localparam int SW   = otca_pkg::SCAN_W;

	// Control state.
	logic [SW-1:0]           n_q;
	logic [MAX_CHANNELS-1:0] free_q;
	logic [SW-1:0]           free_cnt_q;
	logic [SW-1:0]           idx_q;
	logic                    scan_vld_s1;
	logic                    hold_vld_q;
	logic                    out_vld_q;

	// Payload.
	logic [TW-1:0]           owner_mem_q [MAX_CHANNELS];
	logic [TW-1:0]           tag_s1;
	logic [SW-1:0]           scan_idx_s1;
	logic [TW-1:0]           own_q;
	logic [SW-1:0]           rem_q;
	logic [SW-1:0]           ch_q;
	otca_pkg::status_t       pend_st_q;
	logic [SW-1:0]           hold_idx_q;
	logic [SW-1:0]           hold_tot_q;
	otca_pkg::status_t       out_st_q;
	logic [4:0]              out_ch_q;
	logic [15:0]             out_own_q;
	logic                    out_fr_q;
	logic [SW-1:0]           out_tot_q;
	logic                    out_last_q;

	logic [CW-1:0]           idx_a;
	logic [CW-1:0]           s1_a;
	logic [CW-1:0]           ch_a;
	logic [CW-1:0]           rd_a;
	logic [SW-1:0]           n_new;
	logic                    scan_end;
	logic                    out_free;
	logic [15:0]             owner16;
	logic                    a_hit;
	logic                    a_emit;
	logic                    match;
	logic                    consume;
	logic                    adv;
	logic                    r_claim;
	logic                    rd_en;
	logic                    q_free;
	logic                    emit;
	otca_pkg::status_t       e_st;
	logic [4:0]              e_ch;
	logic [15:0]             e_own;
	logic                    e_fr;
	logic [SW-1:0]           e_tot;
	logic                    e_last;

	assign idx_a    = CW'(idx_q);
	assign s1_a     = CW'(scan_idx_s1);
	assign ch_a     = CW'(ch_q);
	assign scan_end = (idx_q >= n_q);
	assign out_free = !out_vld_q || out_ready;
	assign owner16  = 16'(own_q);
	assign q_free   = free_q[ch_a];

	// A write of zero means one channel; anything above the table size means all of it.
	assign n_new = (channels_in_use == '0) ? SW'(1) :
		((32'(channels_in_use) > MAX_CHANNELS) ? SW'(MAX_CHANNELS) : channels_in_use);

	assign a_hit   = !scan_end && free_q[idx_a];
	assign a_emit  = (cmd.op == otca_pkg::OP_ALLOC) && a_hit && out_free;

	assign match   = scan_vld_s1 && !free_q[s1_a] && (tag_s1 == own_q);
	assign consume = !match || !hold_vld_q || out_free;
	assign adv     = !scan_vld_s1 || consume;
	assign r_claim = (cmd.op == otca_pkg::OP_REL) && match && consume;

	assign rd_a  = (cmd.op == otca_pkg::OP_QRD) ? ch_a : idx_a;
	assign rd_en = (cmd.op == otca_pkg::OP_QRD) ||
		((cmd.op == otca_pkg::OP_REL) && adv && !scan_end);

	assign stat.act        = otca_pkg::action_t'(action);
	assign stat.zero_cnt   = (count == '0);
	assign stat.short_cnt  = (count > free_cnt_q);
	assign stat.bad_ch     = (channel >= n_q);
	assign stat.out_free   = out_free;
	assign stat.alloc_done = a_emit && (rem_q == SW'(1));
	assign stat.scan_end   = scan_end;
	assign stat.rel_done   = !scan_vld_s1 && scan_end;

	always_comb begin
		emit   = 1'b0;
		e_st   = otca_pkg::ST_GRANTED;
		e_ch   = '0;
		e_own  = '0;
		e_fr   = 1'b0;
		e_tot  = free_cnt_q;
		e_last = 1'b0;
		case (cmd.op)
			otca_pkg::OP_ALLOC: begin
				emit   = a_emit;
				e_ch   = 5'(idx_q);
				e_own  = owner16;
				e_tot  = free_cnt_q - SW'(1);
				e_last = (rem_q == SW'(1));
			end
			otca_pkg::OP_REL: begin
				emit  = r_claim && hold_vld_q;
				e_st  = otca_pkg::ST_RELEASED;
				e_ch  = 5'(hold_idx_q);
				e_own = owner16;
				e_fr  = 1'b1;
				e_tot = hold_tot_q;
			end
			otca_pkg::OP_REL_END: begin
				emit   = out_free;
				e_own  = owner16;
				e_last = 1'b1;
				if (hold_vld_q) begin
					e_st  = otca_pkg::ST_RELEASED;
					e_ch  = 5'(hold_idx_q);
					e_fr  = 1'b1;
					e_tot = hold_tot_q;
				end else begin
					e_st = otca_pkg::ST_NONE_REL;
				end
			end
			otca_pkg::OP_SINGLE: begin
				emit   = out_free;
				e_st   = pend_st_q;
				e_own  = (pend_st_q == otca_pkg::ST_BAD_CHAN) ? 16'd0 : owner16;
				e_last = 1'b1;
			end
			otca_pkg::OP_QOUT: begin
				emit   = out_free;
				e_st   = otca_pkg::ST_OWNER;
				e_ch   = 5'(ch_q);
				e_fr   = q_free;
				e_own  = q_free ? 16'd0 : 16'(tag_s1);
				e_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= SW'(NRST);
			free_q      <= '1;
			free_cnt_q  <= SW'(NRST);
			idx_q       <= '0;
			scan_vld_s1 <= 1'b0;
			hold_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (cmd.op)
				otca_pkg::OP_CFG: begin
					n_q        <= n_new;
					idx_q      <= '0;
					free_cnt_q <= '0;
				end
				otca_pkg::OP_LOAD: begin
					idx_q       <= '0;
					scan_vld_s1 <= 1'b0;
					hold_vld_q  <= 1'b0;
				end
				otca_pkg::OP_RECOUNT: begin
					if (!scan_end) begin
						free_cnt_q <= free_cnt_q + SW'(free_q[idx_a]);
						idx_q      <= idx_q + SW'(1);
					end
				end
				otca_pkg::OP_ALLOC: begin
					if (!scan_end) begin
						if (a_hit) begin
							if (out_free) begin
								free_q[idx_a] <= 1'b0;
								free_cnt_q    <= free_cnt_q - SW'(1);
								idx_q         <= idx_q + SW'(1);
							end
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
				end
				otca_pkg::OP_REL: begin
					if (r_claim) begin
						free_q[s1_a] <= 1'b1;
						free_cnt_q   <= free_cnt_q + SW'(1);
						hold_vld_q   <= 1'b1;
					end
					if (adv) begin
						if (!scan_end) begin
							scan_vld_s1 <= 1'b1;
							idx_q       <= idx_q + SW'(1);
						end else begin
							scan_vld_s1 <= 1'b0;
						end
					end
				end
				otca_pkg::OP_REL_END: begin
					if (out_free) begin
						hold_vld_q <= 1'b0;
					end
				end
				default: begin
					hold_vld_q <= hold_vld_q;
				end
			endcase
		end
	end

	// Owner tag memory: one write port for grants, one registered read port.
	always_ff @(posedge clk) begin
		if (a_emit) begin
			owner_mem_q[idx_a] <= own_q;
		end
		if (rd_en) begin
			tag_s1 <= owner_mem_q[rd_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == otca_pkg::OP_LOAD) begin
			own_q <= owner_id[TW-1:0];
			rem_q <= count;
			ch_q  <= channel;
			if (otca_pkg::action_t'(action) == otca_pkg::ACT_QUERY) begin
				pend_st_q <= otca_pkg::ST_BAD_CHAN;
			end else if (count == '0) begin
				pend_st_q <= otca_pkg::ST_BAD_COUNT;
			end else begin
				pend_st_q <= otca_pkg::ST_REFUSED;
			end
		end
		if (a_emit) begin
			rem_q <= rem_q - SW'(1);
		end
		if (rd_en && (cmd.op == otca_pkg::OP_REL)) begin
			scan_idx_s1 <= idx_q;
		end
		if (r_claim) begin
			hold_idx_q <= scan_idx_s1;
			hold_tot_q <= free_cnt_q + SW'(1);
		end
		if (emit) begin
			out_st_q   <= e_st;
			out_ch_q   <= e_ch;
			out_own_q  <= e_own;
			out_fr_q   <= e_fr;
			out_tot_q  <= e_tot;
			out_last_q <= e_last;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = out_st_q;
	assign channel_out  = out_ch_q;
	assign owner_out    = out_own_q;
	assign channel_free = out_fr_q;
	assign free_total   = out_tot_q;
	assign last         = out_last_q;

endmodule

// ----- rtl/owner_tagged_channel_allocator.sv -----
// Allocate: the walk covers one channel per cycle while the output is not stalled; each grant is
// registered in the result register. Release: each channel passes the owner memory read stage and
// the hold stage, and a closing step follows the walk. Query: owner memory read, then result.
// One item at a time; result stalls on the output hold the scan where it stands.
// Reset: all channels free, 32 channels in use (fewer if the table is smaller), no result pending.
// A configuration write starts a recount; the next item is accepted once the recount is over.
//
// Top level of the owner-tagged channel allocator. Depends on otca_pkg, otca_ctrl and otca_dpath.
//
// Each channel carries a free mark (flip-flops, all set at reset) and an owner tag held
// in a single-port-write, registered-read memory that is read during release walks and queries.
// The controller decodes each accepted transaction and sequences the datapath: allocate
// walks the channels lowest index first, claiming free ones until the count is met;
// release walks every active channel, keeping the latest freed channel in a hold stage
// so that the final one can be marked last once the walk is over. A running free count
// is kept up to date by every claim and release, and is rebuilt after each write of the
// channels_in_use register, since channels beyond the range keep their marks.
module owner_tagged_channel_allocator #(
	parameter int MAX_CHANNELS = 32,
	parameter int OWNER_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write transactions.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  channels_in_use,
	// Request transactions.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] owner_id,
	input  logic [5:0]  count,
	input  logic [5:0]  channel,
	// Result transactions.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [4:0]  channel_out,
	output logic [15:0] owner_out,
	output logic        channel_free,
	output logic [5:0]  free_total,
	output logic        last
);

	otca_pkg::cmd_t     cmd;
	otca_pkg::dp_stat_t stat;

	// The controller only sequences; every register that holds channel state lives in
	// the datapath.
	otca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.in_ready  (in_ready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	otca_dpath #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.OWNER_BITS   (OWNER_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.owner_id        (owner_id),
		.count           (count),
		.channel         (channel),
		.channels_in_use (channels_in_use),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.channel_out     (channel_out),
		.owner_out       (owner_out),
		.channel_free    (channel_free),
		.free_total      (free_total),
		.last            (last)
	);

endmodule

// ----- rtl/otca_checker.sv -----
// Port-level checker of the owner-tagged channel allocator, bound to the top level.
// Depends on otca_pkg and owner_tagged_channel_allocator_macros.svh.
`include "owner_tagged_channel_allocator_macros.svh"

module otca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [4:0]  channel_out,
	input logic [15:0] owner_out,
	input logic        channel_free,
	input logic        last
);

	// A stalled result keeps its status, channel and last flag.
	`OTCA_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(channel_out) && $stable(last), "result changed while stalled")

	// A granted channel is no longer free; a released one is.
	`OTCA_CHK_NOW(a_grant_taken, out_valid && (status == otca_pkg::ST_GRANTED), !channel_free, "granted channel shown as free")
	`OTCA_CHK_NOW(a_release_free, out_valid && (status == otca_pkg::ST_RELEASED), channel_free, "released channel shown as held")

	// Refusals and error results stand alone and close their transaction.
	`OTCA_CHK_NOW(a_single_last, out_valid && ((status == otca_pkg::ST_REFUSED) || (status == otca_pkg::ST_NONE_REL) || (status == otca_pkg::ST_BAD_COUNT) || (status == otca_pkg::ST_BAD_CHAN)), last && (channel_out == 5'd0) && !channel_free, "single result malformed")

	// A bad channel report names no owner.
	`OTCA_CHK_NOW(a_bad_chan_owner, out_valid && (status == otca_pkg::ST_BAD_CHAN), owner_out == 16'd0, "bad channel report carries an owner")

endmodule

bind owner_tagged_channel_allocator otca_checker u_otca_checker (.*);
